FILE: hw/rtl/swcc_pkg.sv
// Shared types and constants for the sphere-against-walls collision checker.
// Holds the sequencer state type, multiply-accumulate controls and register map.
// No dependencies.
package swcc_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int RAD_W      = 15;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // Wall storage: one slot per wall register
    localparam int WALL_SLOTS    = 7;
    localparam int WALL_IDX_W    = $clog2(WALL_SLOTS);
    localparam int NUM_WALLS_DEF = 7;

    // Shared multiply-accumulate unit
    localparam int OP_W   = 18;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = 70;
    localparam int K_W    = 32;
    localparam int L2_W   = 34;
    localparam int C_W    = 35;
    localparam int HALF_W = 17;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WALL0 = CFG_IDX_W'(1);

    // Reset values
    localparam logic [RAD_W-1:0] LEVEL_HALF_RST = RAD_W'(5120);
    localparam logic [CFG_DATA_W-1:0] WALL_RST [WALL_SLOTS] = '{
        64'hEC00_EC00_1400_EC00,
        64'h1400_EC00_1400_1400,
        64'h1400_1400_EC00_1400,
        64'hEC00_1400_EC00_EC00,
        64'hFB00_FB00_FB00_0500,
        64'h0500_FB00_0500_0500,
        64'hF600_0000_0A00_0000
    };

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_PY,
        ST_SQ_R,
        ST_L_DX,
        ST_L_DZ,
        ST_T_DX,
        ST_T_DZ,
        ST_SEL,
        ST_P_X,
        ST_P_Z,
        ST_C_A,
        ST_C_B,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_WCHK,
        ST_ARENA
    } state_t;

    // Product alignment
    typedef enum logic [1:0] {
        SH_0,
        SH_17,
        SH_18,
        SH_34
    } shift_t;

    // Accumulator addend source
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ACC,
        BASE_K
    } base_t;

    // Controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic                   en;
        logic signed [OP_W-1:0] op_a;
        logic signed [OP_W-1:0] op_b;
        shift_t                 shift;
        base_t                  base;
        logic                   neg;
    } mac_ctrl_t;

endpackage

FILE: hw/rtl/sphere_wall_collision_check.sv
// Sphere-against-walls collision checker, top level.
// One shared 18x18 multiply-accumulate unit under a small sequencer.
// Depends on swcc_pkg.
//
// Usage
//   Input channel (in_valid/in_ready) takes one beat: sphere centre pos_x,
//   pos_y, pos_z and sphere_radius, all Q8.8. Output channel
//   (out_valid/out_ready) returns one beat per input with hit set when the
//   sphere is strictly closer than its radius to any wall segment or reaches
//   past the arena edge in x or z.
//   Configuration channel (cfg_valid/cfg_ready) is always ready; index 0 is
//   the arena half width, indices 1 to 7 the wall segments. Other indices are
//   dropped. Write only while the block is idle.
//   Steps: an item runs the set-up steps ST_SQ_PY and ST_SQ_R, then per wall
//   the length, projection and select steps, then the endpoint steps when the
//   closest point is an endpoint or the cross-term and split-product steps when
//   it lies inside the segment, then the wall check; the arena step comes last.
//   All products and partial products use the single multiplier, one per cycle.
//   One item is in flight at a time; in_ready is low while it is worked on.
//   If the receiver stalls, the finished result waits in the output register;
//   a following item then holds in its last step until that beat is taken.
//   Reset clears the sequencer and output valid, and loads the default arena
//   and seven default walls.
module sphere_wall_collision_check
    import swcc_pkg::*;
#(
    parameter int NUM_WALLS = NUM_WALLS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_W-1:0]    pos_x,
    input  logic signed [COORD_W-1:0]    pos_y,
    input  logic signed [COORD_W-1:0]    pos_z,
    input  logic        [RAD_W-1:0]      sphere_radius,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [WALL_IDX_W-1:0] LAST_WALL = WALL_IDX_W'(NUM_WALLS - 1);

    // Configuration registers
    logic [RAD_W-1:0]      level_half_reg;
    logic [CFG_DATA_W-1:0] wall_reg [WALL_SLOTS];

    // Control registers
    state_t                state_reg, state_next;
    logic [WALL_IDX_W-1:0] wall_idx_reg;
    logic                  hit_acc_reg;
    logic                  out_valid_reg;
    logic                  hit_reg;

    // Datapath registers
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic        [RAD_W-1:0]   rad_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [K_W-1:0]     k_reg;
    logic        [L2_W-1:0]    l2_reg;
    logic signed [C_W-1:0]     c_reg;
    logic                      use_end_reg;

    logic in_fire, cfg_fire, out_fire, can_emit;
    logic [CFG_IDX_W-1:0] wall_sel;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign out_fire  = out_valid_reg && out_ready;
    assign can_emit  = !out_valid_reg || out_ready;
    assign wall_sel  = cfg_index - CFG_WALL0;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_half_reg <= LEVEL_HALF_RST;
            for (int i = 0; i < WALL_SLOTS; i++)
            begin
                wall_reg[i] <= WALL_RST[i];
            end
        end
        else if (cfg_fire)
        begin
            if (cfg_index == CFG_LEVEL)
            begin
                level_half_reg <= cfg_data[RAD_W-1:0];
            end
            else if (cfg_index >= CFG_WALL0 &&
                     cfg_index < CFG_WALL0 + CFG_IDX_W'(WALL_SLOTS))
            begin
                wall_reg[wall_sel[WALL_IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    // Current wall geometry and differences (17-bit signed)
    logic [CFG_DATA_W-1:0]   cur_wall;
    logic signed [16:0]      sx, sz, ex, ez, pxe, pze;
    logic signed [16:0]      dx, dz, bx, bz, fx, fz;

    assign cur_wall = wall_reg[wall_idx_reg];
    assign sx  = {cur_wall[63], cur_wall[63:48]};
    assign sz  = {cur_wall[47], cur_wall[47:32]};
    assign ex  = {cur_wall[31], cur_wall[31:16]};
    assign ez  = {cur_wall[15], cur_wall[15:0]};
    assign pxe = {px_reg[COORD_W-1], px_reg};
    assign pze = {pz_reg[COORD_W-1], pz_reg};
    assign dx  = pxe - sx;
    assign dz  = pze - sz;
    assign bx  = ex - sx;
    assign bz  = ez - sz;
    assign fx  = pxe - ex;
    assign fz  = pze - ez;

    // Split operands for the wide middle-case products
    logic signed [OP_W-1:0] kh, kl, lh, ll, ch, cl;

    assign kh = OP_W'(k_reg >>> HALF_W);
    assign kl = {1'b0, k_reg[HALF_W-1:0]};
    assign lh = {1'b0, l2_reg[L2_W-1:HALF_W]};
    assign ll = {1'b0, l2_reg[HALF_W-1:0]};
    assign ch = c_reg[C_W-1:HALF_W];
    assign cl = {1'b0, c_reg[HALF_W-1:0]};

    // Projection classification from t in the accumulator
    logic t_le0, t_ge_l2;

    assign t_le0   = acc_reg[ACC_W-1] || (acc_reg == '0);
    assign t_ge_l2 = acc_reg >= $signed({{(ACC_W-L2_W){1'b0}}, l2_reg});

    // Arena bounds
    logic signed [OP_W-1:0] h18, r18, lo_lim, hi_lim, px18, pz18;
    logic                   arena_hit;

    assign h18       = {{(OP_W-RAD_W){1'b0}}, level_half_reg};
    assign r18       = {{(OP_W-RAD_W){1'b0}}, rad_reg};
    assign px18      = OP_W'(px_reg);
    assign pz18      = OP_W'(pz_reg);
    assign lo_lim    = r18 - h18;
    assign hi_lim    = h18 - r18;
    assign arena_hit = (px18 < lo_lim) || (px18 > hi_lim) ||
                       (pz18 < lo_lim) || (pz18 > hi_lim);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_SQ_PY;
            ST_SQ_PY: state_next = ST_SQ_R;
            ST_SQ_R:  state_next = ST_L_DX;
            ST_L_DX:  state_next = ST_L_DZ;
            ST_L_DZ:  state_next = ST_T_DX;
            ST_T_DX:  state_next = ST_T_DZ;
            ST_T_DZ:  state_next = ST_SEL;
            ST_SEL:   state_next = (t_le0 || t_ge_l2) ? ST_P_X : ST_C_A;
            ST_P_X:   state_next = ST_P_Z;
            ST_P_Z:   state_next = ST_WCHK;
            ST_C_A:   state_next = ST_C_B;
            ST_C_B:   state_next = ST_M0;
            ST_M0:    state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_M4;
            ST_M4:    state_next = ST_M5;
            ST_M5:    state_next = ST_M6;
            ST_M6:    state_next = ST_WCHK;
            ST_WCHK:  state_next = (wall_idx_reg == LAST_WALL) ? ST_ARENA : ST_L_DX;
            ST_ARENA: if (can_emit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Multiply-accumulate controls per step
    mac_ctrl_t mac;
    logic signed [OP_W-1:0] pt_x, pt_z;

    assign pt_x = use_end_reg ? OP_W'(fx) : OP_W'(dx);
    assign pt_z = use_end_reg ? OP_W'(fz) : OP_W'(dz);

    always_comb
    begin
        mac = '{en: 1'b0, op_a: '0, op_b: '0, shift: SH_0, base: BASE_ZERO, neg: 1'b0};
        unique case (state_reg)
            ST_SQ_PY: mac = '{1'b1, OP_W'(py_reg), OP_W'(py_reg), SH_0, BASE_ZERO, 1'b0};
            ST_SQ_R:  mac = '{1'b1, r18, r18, SH_0, BASE_ACC, 1'b1};
            ST_L_DX:  mac = '{1'b1, OP_W'(bx), OP_W'(bx), SH_0, BASE_ZERO, 1'b0};
            ST_L_DZ:  mac = '{1'b1, OP_W'(bz), OP_W'(bz), SH_0, BASE_ACC, 1'b0};
            ST_T_DX:  mac = '{1'b1, OP_W'(dx), OP_W'(bx), SH_0, BASE_ZERO, 1'b0};
            ST_T_DZ:  mac = '{1'b1, OP_W'(dz), OP_W'(bz), SH_0, BASE_ACC, 1'b0};
            ST_P_X:   mac = '{1'b1, pt_x, pt_x, SH_0, BASE_K, 1'b0};
            ST_P_Z:   mac = '{1'b1, pt_z, pt_z, SH_0, BASE_ACC, 1'b0};
            ST_C_A:   mac = '{1'b1, OP_W'(dz), OP_W'(bx), SH_0, BASE_ZERO, 1'b0};
            ST_C_B:   mac = '{1'b1, OP_W'(dx), OP_W'(bz), SH_0, BASE_ACC, 1'b1};
            ST_M0:    mac = '{1'b1, kh, lh, SH_34, BASE_ZERO, 1'b0};
            ST_M1:    mac = '{1'b1, kh, ll, SH_17, BASE_ACC, 1'b0};
            ST_M2:    mac = '{1'b1, kl, lh, SH_17, BASE_ACC, 1'b0};
            ST_M3:    mac = '{1'b1, kl, ll, SH_0, BASE_ACC, 1'b0};
            ST_M4:    mac = '{1'b1, ch, ch, SH_34, BASE_ACC, 1'b0};
            ST_M5:    mac = '{1'b1, ch, cl, SH_18, BASE_ACC, 1'b0};
            ST_M6:    mac = '{1'b1, cl, cl, SH_0, BASE_ACC, 1'b0};
            default:  mac = '{en: 1'b0, op_a: '0, op_b: '0, shift: SH_0,
                              base: BASE_ZERO, neg: 1'b0};
        endcase
    end

    // Shared multiply-accumulate unit
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext, term, base_val, acc_next;

    assign prod     = mac.op_a * mac.op_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    always_comb
    begin
        unique case (mac.shift)
            SH_0:    term = prod_ext;
            SH_17:   term = prod_ext <<< 17;
            SH_18:   term = prod_ext <<< 18;
            SH_34:   term = prod_ext <<< 34;
            default: term = prod_ext;
        endcase
        unique case (mac.base)
            BASE_ZERO: base_val = '0;
            BASE_ACC:  base_val = acc_reg;
            BASE_K:    base_val = {{(ACC_W-K_W){k_reg[K_W-1]}}, k_reg};
            default:   base_val = '0;
        endcase
        acc_next = mac.neg ? (base_val - term) : (base_val + term);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            rad_reg <= sphere_radius;
        end
        if (mac.en)
        begin
            acc_reg <= acc_next;
        end
        // k = py^2 - r^2 sits in the accumulator on entry to the first wall
        if (state_reg == ST_L_DX && wall_idx_reg == '0)
        begin
            k_reg <= acc_reg[K_W-1:0];
        end
        if (state_reg == ST_T_DX)
        begin
            l2_reg <= acc_reg[L2_W-1:0];
        end
        if (state_reg == ST_SEL)
        begin
            use_end_reg <= !t_le0;
        end
        if (state_reg == ST_M0)
        begin
            c_reg <= acc_reg[C_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wall_idx_reg  <= '0;
            hit_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                wall_idx_reg <= '0;
                hit_acc_reg  <= 1'b0;
            end
            else if (state_reg == ST_WCHK)
            begin
                // negative accumulator: squared distance below radius squared
                hit_acc_reg <= hit_acc_reg | acc_reg[ACC_W-1];
                if (wall_idx_reg != LAST_WALL)
                begin
                    wall_idx_reg <= wall_idx_reg + 1'b1;
                end
            end
            // result beat
            if (state_reg == ST_ARENA && can_emit)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= hit_acc_reg | arena_hit;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_result_from_arena: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_ARENA))
        else $error("result beat raised outside the final step");

    a_wall_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> wall_idx_reg <= LAST_WALL)
        else $error("wall index past the last wall");

    a_mid_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_M0 |-> $past(state_reg == ST_C_B))
        else $error("middle-case products started without the cross term");

    a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(hit_reg))
        else $error("pending result overwritten");

endmodule
